### hw/rtl/cpfl_pkg.sv
// ----------------------------------------------------------------------------
// cpfl_pkg
// Shared types and codes of the cell pool free list allocator.
// ----------------------------------------------------------------------------
package cpfl_pkg;

  localparam int unsigned CellW  = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned BlockW = 11;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_ALLOC   = 2'd0;
  localparam logic [1:0] STATUS_RELEASE = 2'd1;
  localparam logic [1:0] STATUS_NOCAP   = 2'd2;

  localparam logic [BlockW-1:0] BLOCK_RESET = 11'd5;

  typedef struct packed {
    logic             command;
    logic [CellW-1:0] cell_index;
  } cpfl_req_t;

  typedef struct packed {
    logic [CellW-1:0]  granted_cell;
    logic [1:0]        status;
    logic [CountW-1:0] free_count;
  } cpfl_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FILL
  } cpfl_state_e;

endpackage

### hw/rtl/cpfl_link_ram.sv
// ----------------------------------------------------------------------------
// cpfl_link_ram
// Link memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cpfl_link_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/cell_pool_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// cell_pool_free_list_allocator_core
// A release is done in the execute step. An allocate from a non-empty list
// reads the link memory there, and the registered read data yields the new
// list head in the read step. An allocate that finds the list empty first
// links a new block into the link memory, one cell per cycle, and then runs
// the execute step again, or returns a no-capacity status if no block fits.
// The next input transfer is taken once the current result has been placed
// in the output register, so a result waiting downstream does not hold off
// the next item until that item's own result is ready.
// ----------------------------------------------------------------------------
module cell_pool_free_list_allocator_core #(
  parameter int unsigned MAX_CELLS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cpfl_pkg::cpfl_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cpfl_pkg::cpfl_rsp_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [10:0]         cfg_data_i
);

  import cpfl_pkg::*;

  localparam int unsigned CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned NW = $clog2(MAX_CELLS + 1);
  localparam int unsigned SW = ((NW > BlockW) ? NW : BlockW) + 1;
  localparam int unsigned LW = CW + 1;
  localparam logic [SW-1:0] MaxSum   = SW'(MAX_CELLS);
  localparam logic [NW-1:0] MaxCount = NW'(MAX_CELLS);
  localparam logic [31:0]   MaxIdx   = 32'(MAX_CELLS);

  cpfl_state_e       state_q, state_d;
  cpfl_req_t         req_q, req_d;
  logic [CW-1:0]     head_q, head_d;
  logic              head_valid_q, head_valid_d;
  logic [NW-1:0]     free_q, free_d;
  logic [NW-1:0]     claimed_q, claimed_d;
  logic [BlockW-1:0] cpb_q, cpb_d;
  logic [CW-1:0]     fill_addr_q, fill_addr_d;
  logic [BlockW-1:0] fill_left_q, fill_left_d;
  logic              out_valid_q, out_valid_d;
  cpfl_rsp_t         out_data_q, out_data_d;

  logic          ram_we, ram_re;
  logic [CW-1:0] ram_waddr, ram_raddr;
  logic [LW-1:0] ram_wdata, ram_rdata;

  logic          slot_free, is_alloc, cap_ok, rel_ok, fill_last;
  logic [SW-1:0] claim_sum, free_sum;
  logic [CW-1:0] rel_addr;

  assign slot_free = !out_valid_q || out_ready_i;
  assign is_alloc  = (req_q.command == CMD_ALLOC);
  assign claim_sum = SW'(claimed_q) + SW'(cpb_q);
  assign free_sum  = SW'(free_q) + SW'(cpb_q);
  assign cap_ok    = (cpb_q != '0) && (claim_sum <= MaxSum);
  assign rel_ok    = ({22'd0, req_q.cell_index} < MaxIdx);
  assign rel_addr  = CW'(req_q.cell_index);
  assign fill_last = (fill_left_q == BlockW'(1));

  always_comb begin
    cpb_d = cpb_q;
    if (cfg_valid_i) begin
      cpb_d = cfg_data_i;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!is_alloc) begin
          if (slot_free) begin
            state_d = ST_IDLE;
          end
        end else if (head_valid_q) begin
          state_d = ST_READ;
        end else if (cap_ok) begin
          state_d = ST_FILL;
        end else if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_d = ST_EXEC;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_d        = req_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    free_d       = free_q;
    claimed_d    = claimed_q;
    fill_addr_d  = fill_addr_q;
    fill_left_d  = fill_left_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    ram_we       = 1'b0;
    ram_waddr    = fill_addr_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = head_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
        end
      end
      ST_EXEC: begin
        if (!is_alloc) begin
          if (slot_free) begin
            if (rel_ok) begin
              ram_we       = 1'b1;
              ram_waddr    = rel_addr;
              ram_wdata    = {!head_valid_q, head_q};
              head_d       = rel_addr;
              head_valid_d = 1'b1;
              if (free_q < MaxCount) begin
                free_d = free_q + NW'(1);
              end
            end
            out_valid_d             = 1'b1;
            out_data_d.granted_cell = '0;
            out_data_d.status       = STATUS_RELEASE;
            out_data_d.free_count   = CountW'(free_d);
          end
        end else if (head_valid_q) begin
          ram_re    = 1'b1;
          ram_raddr = head_q;
        end else if (cap_ok) begin
          fill_addr_d = CW'(claimed_q);
          fill_left_d = cpb_q;
        end else if (slot_free) begin
          out_valid_d             = 1'b1;
          out_data_d.granted_cell = '0;
          out_data_d.status       = STATUS_NOCAP;
          out_data_d.free_count   = CountW'(free_q);
        end
      end
      ST_READ: begin
        if (slot_free) begin
          head_d       = ram_rdata[CW-1:0];
          head_valid_d = !ram_rdata[CW];
          if (free_q != '0) begin
            free_d = free_q - NW'(1);
          end
          out_valid_d             = 1'b1;
          out_data_d.granted_cell = CellW'(head_q);
          out_data_d.status       = STATUS_ALLOC;
          out_data_d.free_count   = CountW'(free_d);
        end
      end
      ST_FILL: begin
        ram_we      = 1'b1;
        ram_waddr   = fill_addr_q;
        ram_wdata   = fill_last ? {1'b1, {CW{1'b0}}} : {1'b0, fill_addr_q + CW'(1)};
        fill_addr_d = fill_addr_q + CW'(1);
        fill_left_d = fill_left_q - BlockW'(1);
        if (fill_last) begin
          head_d       = CW'(claimed_q);
          head_valid_d = 1'b1;
          free_d       = (free_sum > MaxSum) ? MaxCount : NW'(free_sum);
          claimed_d    = NW'(claim_sum);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      head_valid_q <= 1'b0;
      free_q       <= '0;
      claimed_q    <= '0;
      cpb_q        <= BLOCK_RESET;
      fill_left_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      free_q       <= free_d;
      claimed_q    <= claimed_d;
      cpb_q        <= cpb_d;
      fill_left_q  <= fill_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    fill_addr_q <= fill_addr_d;
    out_data_q  <= out_data_d;
  end

  cpfl_link_ram #(
    .Depth (MAX_CELLS),
    .AddrW (CW),
    .DataW (LW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

`ifndef NO_ASSERTIONS
  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= MaxCount)
    else $error("free count exceeds the pool size");

  a_claimed_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    claimed_q <= MaxCount)
    else $error("claimed cells exceed the pool size");

  a_fill_on_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> !head_valid_q)
    else $error("block fill while the free list is not empty");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |->
      ($past(state_q) == ST_EXEC || $past(state_q) == ST_READ))
    else $error("result produced outside an execute or read step");
`endif

endmodule
